FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the arc/segment crossing block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define AASI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be observed while out of reset.
`define AASI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: sv/aasi_pkg.sv
// ----------------------------------------------------------------------------
// aasi_pkg
// Types and constants shared by the arc/segment crossing pipeline.
// ----------------------------------------------------------------------------
package aasi_pkg;

  // Coordinate word and derived widths.
  localparam int CoordBits    = 32;
  localparam int RadBits      = CoordBits - 1;
  localparam int RootBits     = RadBits;
  localparam int RadicandBits = 2 * RootBits;
  localparam int CfgBits      = CoordBits;

  // Accept edge to result edge: setup stage, multiply stage, one cell per
  // root bit, and the output register.
  localparam int PipeLatency  = RootBits + 3;

  // Quadrant codes; anything else behaves as the +x -y quadrant.
  localparam logic [2:0] QuadPxPy = 3'd1;
  localparam logic [2:0] QuadNxPy = 3'd2;
  localparam logic [2:0] QuadNxNy = 3'd3;
  localparam logic [2:0] QuadPxNy = 3'd4;

  localparam logic [RadBits-1:0] RadiusReset = RadBits'(65536);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_ARC_RADIUS   = 2'd2,
    REG_ARC_QUADRANT = 2'd3
  } aasi_reg_e;

  // One segment query.
  typedef struct packed {
    logic                        operation;
    logic signed [CoordBits-1:0] line_pos;
    logic signed [CoordBits-1:0] span_low;
    logic signed [CoordBits-1:0] span_high;
  } aasi_item_t;

  // One crossing result.
  typedef struct packed {
    logic                        hit;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
  } aasi_result_t;

  // Per-query values that ride along with the square root.
  typedef struct packed {
    logic                        vertical;
    logic                        in_reach;
    logic                        free_pos;
    logic signed [CoordBits-1:0] pos;
    logic signed [CoordBits-1:0] span_low;
    logic signed [CoordBits-1:0] span_high;
    logic signed [CoordBits-1:0] cfree;
  } aasi_side_t;

  // Contents handed from one square-root cell to the next.
  typedef struct packed {
    logic                      valid;
    logic [RootBits:0]         rem;
    logic [RootBits-1:0]       root;
    logic [RadicandBits-1:0]   rad;
    aasi_side_t                side;
  } aasi_cell_t;

endpackage

FILE: sv/aasi_prep.sv
// ----------------------------------------------------------------------------
// aasi_prep
// Picks the fixed and free axes, range-checks the distance from the center
// and forms the radicand r*r - d*d as (r - d) * (r + d).
// ----------------------------------------------------------------------------
module aasi_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  aasi_pkg::aasi_item_t                item_i,
  input  logic signed [aasi_pkg::CoordBits-1:0] center_x_i,
  input  logic signed [aasi_pkg::CoordBits-1:0] center_y_i,
  input  logic [aasi_pkg::RadBits-1:0]        radius_i,
  input  logic [2:0]                          quadrant_i,
  output aasi_pkg::aasi_cell_t                cell_o
);
  import aasi_pkg::*;

  logic                 pos_x;
  logic                 pos_y;
  logic                 fixed_pos;
  logic [CoordBits-1:0] cfix;
  aasi_side_t           side_d;
  logic [CoordBits:0]   delta;
  logic [RadBits-1:0]   diff_d;
  logic [CoordBits-1:0] sum_d;

  logic                 s1_valid_q;
  aasi_side_t           s1_side_q;
  logic [RadBits-1:0]   s1_diff_q;
  logic [CoordBits-1:0] s1_sum_q;

  logic [RadBits+CoordBits-1:0] prod;
  logic                         s2_valid_q;
  logic [RadicandBits-1:0]      s2_rad_q;
  aasi_side_t                   s2_side_q;

  // Direction of the arc along x and y for the configured quadrant.
  always_comb begin
    case (quadrant_i)
      QuadPxPy: begin
        pos_x = 1'b1;
        pos_y = 1'b1;
      end
      QuadNxPy: begin
        pos_x = 1'b0;
        pos_y = 1'b1;
      end
      QuadNxNy: begin
        pos_x = 1'b0;
        pos_y = 1'b0;
      end
      default: begin
        pos_x = 1'b1;
        pos_y = 1'b0;
      end
    endcase
  end

  // Axis selection and distance from the center on the arc's side.
  always_comb begin
    side_d.vertical  = item_i.operation;
    side_d.pos       = item_i.line_pos;
    side_d.span_low  = item_i.span_low;
    side_d.span_high = item_i.span_high;
    if (item_i.operation) begin
      fixed_pos       = pos_x;
      side_d.free_pos = pos_y;
      cfix            = center_x_i;
      side_d.cfree    = center_y_i;
    end else begin
      fixed_pos       = pos_y;
      side_d.free_pos = pos_x;
      cfix            = center_y_i;
      side_d.cfree    = center_x_i;
    end
    if (fixed_pos) begin
      delta = {item_i.line_pos[CoordBits-1], item_i.line_pos} - {cfix[CoordBits-1], cfix};
    end else begin
      delta = {cfix[CoordBits-1], cfix} - {item_i.line_pos[CoordBits-1], item_i.line_pos};
    end
    side_d.in_reach = !delta[CoordBits] && (delta[CoordBits-1:0] <= {1'b0, radius_i});
    diff_d = radius_i - delta[RadBits-1:0];
    sum_d  = {1'b0, radius_i} + delta[CoordBits-1:0];
  end

  // Setup stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
    end
  end

  // Setup stage payload.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_side_q <= side_d;
      s1_diff_q <= diff_d;
      s1_sum_q  <= sum_d;
    end
  end

  // The product stays below 2^(2*RootBits) whenever the distance is in range.
  assign prod = s1_diff_q * s1_sum_q;

  // Multiply stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Multiply stage payload.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_rad_q  <= prod[RadicandBits-1:0];
      s2_side_q <= s1_side_q;
    end
  end

  // Seed for the first square-root cell.
  always_comb begin
    cell_o.valid = s2_valid_q;
    cell_o.rem   = '0;
    cell_o.root  = '0;
    cell_o.rad   = s2_rad_q;
    cell_o.side  = s2_side_q;
  end

endmodule

FILE: sv/aasi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aasi_sqrt_cell
// One step of a restoring integer square root: settles one root bit and
// passes remainder, partial root and remaining radicand bits onward.
// ----------------------------------------------------------------------------
module aasi_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aasi_pkg::aasi_cell_t cell_i,
  output aasi_pkg::aasi_cell_t cell_o
);
  import aasi_pkg::*;

  logic [RootBits+2:0] rem_sh;
  logic [RootBits+2:0] trial;
  logic [RootBits+2:0] rem_sub;
  logic                take;
  aasi_cell_t          cell_d;
  logic                valid_q;
  aasi_cell_t          cell_q;

  // Bring in the next two radicand bits and try the bit as one.
  always_comb begin
    rem_sh  = {cell_i.rem, cell_i.rad[RadicandBits-1 -: 2]};
    trial   = {1'b0, cell_i.root, 2'b01};
    rem_sub = rem_sh - trial;
    take    = (rem_sh >= trial);
    cell_d       = cell_i;
    cell_d.rem   = take ? rem_sub[RootBits:0] : rem_sh[RootBits:0];
    cell_d.root  = {cell_i.root[RootBits-2:0], take};
    cell_d.rad   = {cell_i.rad[RadicandBits-3:0], 2'b00};
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // Payload follows a valid transaction.
  always_ff @(posedge clk_i) begin
    if (cell_i.valid) begin
      cell_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

FILE: sv/aasi_finish.sv
// ----------------------------------------------------------------------------
// aasi_finish
// Places the offset on the free axis, tests it against the segment span and
// registers the result for one strobe cycle.
// ----------------------------------------------------------------------------
module aasi_finish (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aasi_pkg::aasi_cell_t   cell_i,
  output logic                   done_o,
  output aasi_pkg::aasi_result_t result_o
);
  import aasi_pkg::*;

  logic signed [CoordBits+1:0] cfree_x;
  logic signed [CoordBits+1:0] root_x;
  logic signed [CoordBits+1:0] lo_x;
  logic signed [CoordBits+1:0] hi_x;
  logic signed [CoordBits+1:0] coord;
  aasi_result_t                result_d;
  logic                        done_q;
  aasi_result_t                result_q;

  // Full-precision crossing coordinate and span test.
  always_comb begin
    cfree_x = {{2{cell_i.side.cfree[CoordBits-1]}}, cell_i.side.cfree};
    root_x  = {3'b000, cell_i.root};
    lo_x    = {{2{cell_i.side.span_low[CoordBits-1]}}, cell_i.side.span_low};
    hi_x    = {{2{cell_i.side.span_high[CoordBits-1]}}, cell_i.side.span_high};
    coord   = cell_i.side.free_pos ? (cfree_x + root_x) : (cfree_x - root_x);

    result_d.hit = cell_i.side.in_reach && (coord >= lo_x) && (coord <= hi_x);
    if (!result_d.hit) begin
      result_d.point_x = '0;
      result_d.point_y = '0;
    end else if (cell_i.side.vertical) begin
      result_d.point_x = cell_i.side.pos;
      result_d.point_y = coord[CoordBits-1:0];
    end else begin
      result_d.point_x = coord[CoordBits-1:0];
      result_d.point_y = cell_i.side.pos;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cell_i.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cell_i.valid) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: sv/arc_axis_segment_intersect_core.sv
// ----------------------------------------------------------------------------
// arc_axis_segment_intersect_core
// done_o rises once the query taken with start_i has passed the setup
// stage, the multiply stage, 31 root cells and the output register;
// result_o is valid while done_o is high.
// Throughput: one query per cycle; busy_o stays low, the cell row is fully
// pipelined and the receiver never stalls it.
// Reset: rst_ni clears all valid flags; the arc resets to center (0, 0),
// radius 65536 and the +x +y quadrant.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arc_axis_segment_intersect_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  aasi_pkg::aasi_item_t          item_i,
  output logic                          done_o,
  output aasi_pkg::aasi_result_t        result_o,
  input  logic                          cfg_we_i,
  input  aasi_pkg::aasi_reg_e           cfg_idx_i,
  input  logic [aasi_pkg::CfgBits-1:0]  cfg_wdata_i
);
  import aasi_pkg::*;

  logic signed [CoordBits-1:0] center_x_q;
  logic signed [CoordBits-1:0] center_y_q;
  logic [RadBits-1:0]          radius_q;
  logic [2:0]                  quadrant_q;
  logic                        take;
  logic                        miss_point;
  aasi_cell_t                  chain [RootBits+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= RadiusReset;
      quadrant_q <= QuadPxPy;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X:     center_x_q <= cfg_wdata_i[CoordBits-1:0];
        REG_CENTER_Y:     center_y_q <= cfg_wdata_i[CoordBits-1:0];
        REG_ARC_RADIUS:   radius_q   <= cfg_wdata_i[RadBits-1:0];
        REG_ARC_QUADRANT: quadrant_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // A new query can be taken in every cycle.
  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  aasi_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .radius_i   (radius_q),
    .quadrant_i (quadrant_q),
    .cell_o     (chain[0])
  );

  // Row of square-root cells, one root bit each, most significant first.
  for (genvar k = 0; k < RootBits; k++) begin : g_cell
    aasi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  aasi_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (chain[RootBits]),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // A miss must report the point as zero.
  assign miss_point = !result_o.hit && ((result_o.point_x != '0) || (result_o.point_y != '0));

  // Every result strobe traces back to a transaction taken a fixed time earlier.
  `AASI_ASSERT_IMPL(a_latency, clk_i, rst_ni, done_o, $past(take, PipeLatency), "stray result")

  // A miss reports the point as zero.
  `AASI_ASSERT_NEVER(a_miss_zero, clk_i, rst_ni, done_o && miss_point, "miss with nonzero point")

endmodule
